/* rtl/loc_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// loc_pkg
// Shared codes, states and control bundles of the lock order checker.
// ----------------------------------------------------------------------------
package loc_pkg;

   localparam logic [2:0] MODE_ACQUIRE = 3'd0;
   localparam logic [2:0] MODE_RELEASE = 3'd1;
   localparam logic [2:0] MODE_CHECK   = 3'd2;
   localparam logic [2:0] MODE_QUERY   = 3'd3;
   localparam logic [2:0] MODE_DELETE  = 3'd4;

   typedef enum logic [2:0] {
      ST_OK        = 3'd0,
      ST_DOUBLE    = 3'd1,
      ST_DEADLOCK  = 3'd2,
      ST_NOT_LAST  = 3'd3,
      ST_OVERFLOW  = 3'd4,
      ST_UNDERFLOW = 3'd5
   } status_type;

   typedef enum logic [1:0] {
      MRD_LK,
      MRD_E,
      MRD_R
   } mat_rd_type;

   typedef enum logic [1:0] {
      MWR_NONE,
      MWR_ORDER,
      MWR_CLEAR
   } mat_wr_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_LOAD,
      S_DISP,
      S_AENT,
      S_AROW,
      S_QA,
      S_QB,
      S_CWT,
      S_CHK,
      S_DRD,
      S_DWR,
      S_INC,
      S_DEC,
      S_DONE
   } state_type;

   typedef struct packed {
      logic       take;
      logic       ctx_load;
      logic       push;
      logic       j_inc;
      logic       cnt_inc;
      logic       cnt_dec;
      mat_rd_type mat_rd;
      mat_wr_type mat_wr;
      logic       r_inc;
      logic       set_st;
      status_type st;
      logic       set_conflict;
      logic       set_held;
      logic       emit;
   } cmd_type;

   typedef struct packed {
      logic [2:0] mode;
      logic       rec;
      logic       rd_full;
      logic       rd_zero;
      logic       e_match;
      logic       row_has_lk;
      logic       rev_set;
      logic       j_at_cnt;
      logic       j1_at_cnt;
      logic       r_last;
      logic       out_free;
   } flags_type;

endpackage

/* rtl/loc_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// loc_ctrl
// Sequencer: steps each word through lookup, stack scan or matrix sweep.
// ----------------------------------------------------------------------------
module loc_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_tvalid,
   output logic               req_tready,
   input  loc_pkg::flags_type flags,
   output loc_pkg::cmd_type   cmd
);

   loc_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= loc_pkg::S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      cmd.mat_rd = loc_pkg::MRD_LK;
      cmd.mat_wr = loc_pkg::MWR_NONE;
      cmd.st     = loc_pkg::ST_OK;
      req_tready = 1'b0;
      case (state_ff)
         loc_pkg::S_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.take = 1'b1;
               state_in = loc_pkg::S_LOAD;
            end
         end
         loc_pkg::S_LOAD: begin
            state_in = loc_pkg::S_DISP;
         end
         loc_pkg::S_DISP: begin
            cmd.ctx_load = 1'b1;
            state_in     = loc_pkg::S_DONE;
            case (flags.mode)
               loc_pkg::MODE_ACQUIRE: begin
                  if (flags.rd_full) begin
                     cmd.set_st = 1'b1;
                     cmd.st     = loc_pkg::ST_OVERFLOW;
                  end else begin
                     cmd.push = 1'b1;
                     state_in = flags.rd_zero ? loc_pkg::S_INC : loc_pkg::S_AENT;
                  end
               end
               loc_pkg::MODE_RELEASE: begin
                  if (flags.rd_zero) begin
                     cmd.set_st = 1'b1;
                     cmd.st     = loc_pkg::ST_UNDERFLOW;
                  end else begin
                     state_in = loc_pkg::S_DEC;
                  end
               end
               loc_pkg::MODE_CHECK: begin
                  if (flags.rd_zero) begin
                     cmd.set_st = 1'b1;
                     cmd.st     = loc_pkg::ST_NOT_LAST;
                  end else begin
                     state_in = loc_pkg::S_CWT;
                  end
               end
               loc_pkg::MODE_QUERY: begin
                  if (!flags.rd_zero) begin
                     state_in = loc_pkg::S_QA;
                  end
               end
               loc_pkg::MODE_DELETE: begin
                  state_in = loc_pkg::S_DRD;
               end
               default: begin
                  state_in = loc_pkg::S_DONE;
               end
            endcase
         end
         loc_pkg::S_AENT: begin
            cmd.j_inc  = 1'b1;
            cmd.mat_rd = loc_pkg::MRD_E;
            if (flags.e_match) begin
               if (flags.rec) begin
                  state_in = loc_pkg::S_INC;
               end else begin
                  cmd.set_st       = 1'b1;
                  cmd.st           = loc_pkg::ST_DOUBLE;
                  cmd.set_conflict = 1'b1;
                  state_in         = loc_pkg::S_DONE;
               end
            end else begin
               state_in = loc_pkg::S_AROW;
            end
         end
         loc_pkg::S_AROW: begin
            if (!flags.row_has_lk && flags.rev_set) begin
               cmd.set_st       = 1'b1;
               cmd.st           = loc_pkg::ST_DEADLOCK;
               cmd.set_conflict = 1'b1;
               state_in         = loc_pkg::S_DONE;
            end else begin
               if (!flags.row_has_lk) begin
                  cmd.mat_wr = loc_pkg::MWR_ORDER;
               end
               state_in = flags.j_at_cnt ? loc_pkg::S_INC : loc_pkg::S_AENT;
            end
         end
         loc_pkg::S_QA: begin
            cmd.j_inc = 1'b1;
            if (flags.e_match) begin
               cmd.set_held = 1'b1;
               state_in     = loc_pkg::S_DONE;
            end else begin
               state_in = flags.j1_at_cnt ? loc_pkg::S_DONE : loc_pkg::S_QB;
            end
         end
         loc_pkg::S_QB: begin
            state_in = loc_pkg::S_QA;
         end
         loc_pkg::S_CWT: begin
            state_in = loc_pkg::S_CHK;
         end
         loc_pkg::S_CHK: begin
            if (!flags.e_match) begin
               cmd.set_st = 1'b1;
               cmd.st     = loc_pkg::ST_NOT_LAST;
            end
            state_in = loc_pkg::S_DONE;
         end
         loc_pkg::S_DRD: begin
            cmd.mat_rd = loc_pkg::MRD_R;
            state_in   = loc_pkg::S_DWR;
         end
         loc_pkg::S_DWR: begin
            cmd.mat_wr = loc_pkg::MWR_CLEAR;
            cmd.r_inc  = 1'b1;
            state_in   = flags.r_last ? loc_pkg::S_DONE : loc_pkg::S_DRD;
         end
         loc_pkg::S_INC: begin
            cmd.cnt_inc = 1'b1;
            state_in    = loc_pkg::S_DONE;
         end
         loc_pkg::S_DEC: begin
            cmd.cnt_dec = 1'b1;
            state_in    = loc_pkg::S_DONE;
         end
         loc_pkg::S_DONE: begin
            if (flags.out_free) begin
               cmd.emit = 1'b1;
               state_in = loc_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = loc_pkg::S_IDLE;
         end
      endcase
   end

endmodule

/* rtl/loc_dp.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// loc_dp
// Datapath: lock stacks, stack counts, order matrix and result register.
// ----------------------------------------------------------------------------
module loc_dp #(
   parameter int THREADS     = 8,
   parameter int LOCKS       = 64,
   parameter int STACK_DEPTH = 16,
   parameter int CNT_W       = 5
) (
   input  logic               clock,
   input  logic               reset,
   input  logic [2:0]         req_mode,
   input  logic [2:0]         req_thread_id,
   input  logic [5:0]         req_lock_id,
   input  logic               req_is_recursive,
   input  loc_pkg::cmd_type   cmd,
   output loc_pkg::flags_type flags,
   input  logic               rsp_tready,
   output logic               rsp_tvalid,
   output logic [2:0]         rsp_status,
   output logic [5:0]         rsp_conflict_lock,
   output logic               rsp_held,
   output logic [CNT_W-1:0]   rsp_stack_level,
   output logic               rsp_stack_empty
);

   localparam int TH_W  = (THREADS > 1) ? $clog2(THREADS) : 1;
   localparam int LK_W  = $clog2(LOCKS);
   localparam int SDEP  = THREADS * STACK_DEPTH;
   localparam int SA_W  = (SDEP > 1) ? $clog2(SDEP) : 1;

   function automatic logic [TH_W-1:0] th_mod(input logic [2:0] v);
      int x;
      x = int'(v);
      for (int k = 2; k >= 0; k--) begin
         if (x >= (THREADS << k)) x = x - (THREADS << k);
      end
      return TH_W'(x);
   endfunction

   function automatic logic [5:0] lk_mod(input logic [5:0] v);
      int x;
      x = int'(v);
      for (int k = 4; k >= 0; k--) begin
         if (x >= (LOCKS << k)) x = x - (LOCKS << k);
      end
      return 6'(x);
   endfunction

   logic [5:0]       stk_ram_ff [SDEP];
   logic [CNT_W-1:0] cnt_ram_ff [THREADS];
   logic [LOCKS-1:0] mat_ram_ff [LOCKS];

   logic [THREADS-1:0] cnt_vld_ff, cnt_vld_in;
   logic [LOCKS-1:0]   row_vld_ff, row_vld_in;
   logic               rsp_valid_ff, rsp_valid_in;

   logic [2:0]       mode_ff, mode_in;
   logic [TH_W-1:0]  th_ff, th_in;
   logic [5:0]       lk_ff, lk_in;
   logic             rec_ff, rec_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [LOCKS-1:0] rowlk_ff, rowlk_in;
   logic [CNT_W-1:0] j_ff, j_in;
   logic [LK_W-1:0]  r_ff, r_in;
   logic [2:0]       st_ff, st_in;
   logic [5:0]       conf_ff, conf_in;
   logic             held_ff, held_in;

   logic [2:0]       o_st_ff, o_st_in;
   logic [5:0]       o_conf_ff, o_conf_in;
   logic             o_held_ff, o_held_in;
   logic [CNT_W-1:0] o_lvl_ff, o_lvl_in;

   logic [5:0]       stk_q_ff;
   logic [CNT_W-1:0] cnt_q_ff;
   logic             cnt_vq_ff;
   logic [LOCKS-1:0] mat_q_ff;
   logic             mat_vq_ff;

   logic [CNT_W-1:0] cnt_rd;
   logic [LOCKS-1:0] row_cur;
   logic [LOCKS-1:0] lk_bit;
   logic [LK_W-1:0]  e_idx;
   logic [CNT_W-1:0] stk_off;
   logic [SA_W-1:0]  stk_rd_addr;
   logic [SA_W-1:0]  stk_wr_addr;
   logic [LK_W-1:0]  mat_rd_addr;
   logic [LK_W-1:0]  mat_wr_addr;
   logic [LOCKS-1:0] mat_wr_data;
   logic             mat_we;

   assign cnt_rd  = cnt_vq_ff ? cnt_q_ff : '0;
   assign row_cur = mat_vq_ff ? mat_q_ff : '0;
   assign lk_bit  = LOCKS'(1) << lk_ff[LK_W-1:0];
   assign e_idx   = stk_q_ff[LK_W-1:0];
   assign stk_off = (mode_ff == loc_pkg::MODE_CHECK) ? cnt_ff - CNT_W'(1) : j_ff;

   assign stk_rd_addr = SA_W'(int'(th_ff) * STACK_DEPTH + int'(stk_off));
   assign stk_wr_addr = SA_W'(int'(th_ff) * STACK_DEPTH + int'(cnt_rd));

   always_comb begin
      case (cmd.mat_rd)
         loc_pkg::MRD_E: mat_rd_addr = e_idx;
         loc_pkg::MRD_R: mat_rd_addr = r_ff;
         default:        mat_rd_addr = lk_ff[LK_W-1:0];
      endcase
      mat_we = 1'b0;
      case (cmd.mat_wr)
         loc_pkg::MWR_ORDER: begin
            mat_we      = 1'b1;
            mat_wr_addr = e_idx;
            mat_wr_data = row_cur | lk_bit;
         end
         loc_pkg::MWR_CLEAR: begin
            mat_we      = 1'b1;
            mat_wr_addr = r_ff;
            mat_wr_data = (r_ff == lk_ff[LK_W-1:0]) ? '0 : (row_cur & ~lk_bit);
         end
         default: begin
            mat_wr_addr = r_ff;
            mat_wr_data = row_cur;
         end
      endcase
   end

   always_comb begin
      flags.mode       = mode_ff;
      flags.rec        = rec_ff;
      flags.rd_full    = (cnt_rd >= CNT_W'(STACK_DEPTH));
      flags.rd_zero    = (cnt_rd == '0);
      flags.e_match    = (stk_q_ff == lk_ff);
      flags.row_has_lk = row_cur[lk_ff[LK_W-1:0]];
      flags.rev_set    = rowlk_ff[e_idx];
      flags.j_at_cnt   = (j_ff == cnt_ff);
      flags.j1_at_cnt  = ((j_ff + CNT_W'(1)) == cnt_ff);
      flags.r_last     = (r_ff == LK_W'(LOCKS - 1));
      flags.out_free   = !rsp_valid_ff || rsp_tready;
   end

   always_comb begin
      mode_in      = mode_ff;
      th_in        = th_ff;
      lk_in        = lk_ff;
      rec_in       = rec_ff;
      cnt_in       = cnt_ff;
      rowlk_in     = rowlk_ff;
      j_in         = j_ff;
      r_in         = r_ff;
      st_in        = st_ff;
      conf_in      = conf_ff;
      held_in      = held_ff;
      o_st_in      = o_st_ff;
      o_conf_in    = o_conf_ff;
      o_held_in    = o_held_ff;
      o_lvl_in     = o_lvl_ff;
      cnt_vld_in   = cnt_vld_ff;
      row_vld_in   = row_vld_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      if (cmd.take) begin
         mode_in = req_mode;
         th_in   = th_mod(req_thread_id);
         lk_in   = lk_mod(req_lock_id);
         rec_in  = req_is_recursive;
         j_in    = '0;
         r_in    = '0;
         st_in   = loc_pkg::ST_OK;
         conf_in = '0;
         held_in = 1'b0;
      end
      if (cmd.ctx_load) begin
         cnt_in   = cnt_rd;
         rowlk_in = row_cur;
      end
      if (cmd.cnt_inc) cnt_in = cnt_ff + CNT_W'(1);
      if (cmd.cnt_dec) cnt_in = cnt_ff - CNT_W'(1);
      if (cmd.j_inc)   j_in = j_ff + CNT_W'(1);
      if (cmd.r_inc)   r_in = r_ff + LK_W'(1);
      if (cmd.set_st)       st_in   = cmd.st;
      if (cmd.set_conflict) conf_in = stk_q_ff;
      if (cmd.set_held)     held_in = 1'b1;
      if (mat_we)           row_vld_in[mat_wr_addr] = 1'b1;
      if (cmd.emit) begin
         rsp_valid_in      = 1'b1;
         o_st_in           = st_ff;
         o_conf_in         = conf_ff;
         o_held_in         = held_ff;
         o_lvl_in          = cnt_ff;
         cnt_vld_in[th_ff] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_vld_ff   <= '0;
         row_vld_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         cnt_vld_ff   <= cnt_vld_in;
         row_vld_ff   <= row_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      mode_ff   <= mode_in;
      th_ff     <= th_in;
      lk_ff     <= lk_in;
      rec_ff    <= rec_in;
      cnt_ff    <= cnt_in;
      rowlk_ff  <= rowlk_in;
      j_ff      <= j_in;
      r_ff      <= r_in;
      st_ff     <= st_in;
      conf_ff   <= conf_in;
      held_ff   <= held_in;
      o_st_ff   <= o_st_in;
      o_conf_ff <= o_conf_in;
      o_held_ff <= o_held_in;
      o_lvl_ff  <= o_lvl_in;
   end

   always_ff @(posedge clock) begin
      if (cmd.push) stk_ram_ff[stk_wr_addr] <= lk_ff;
      stk_q_ff <= stk_ram_ff[stk_rd_addr];
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) cnt_ram_ff[th_ff] <= cnt_ff;
      cnt_q_ff  <= cnt_ram_ff[th_ff];
      cnt_vq_ff <= cnt_vld_ff[th_ff];
   end

   always_ff @(posedge clock) begin
      if (mat_we) mat_ram_ff[mat_wr_addr] <= mat_wr_data;
      mat_q_ff  <= mat_ram_ff[mat_rd_addr];
      mat_vq_ff <= row_vld_ff[mat_rd_addr];
   end

   assign rsp_tvalid        = rsp_valid_ff;
   assign rsp_status        = o_st_ff;
   assign rsp_conflict_lock = o_conf_ff;
   assign rsp_held          = o_held_ff;
   assign rsp_stack_level   = o_lvl_ff;
   assign rsp_stack_empty   = (o_lvl_ff == '0);

endmodule

/* rtl/lock_order_checker_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lock_order_checker_top
// Lock order checker: per-thread lock stacks and a lock-before-lock matrix.
// ----------------------------------------------------------------------------
// One request word on req_* gives one response word on rsp_*. Requests are
// taken only while the sequencer is idle; one word is in flight at a time.
// Overflow, underflow, unused modes, an empty-stack check and a query of an
// empty stack go straight to the response. Release and acquire on an empty
// stack also update the stack count; check-last reads the top stack entry;
// query scans the stack entries until it finds the lock; acquire scans the
// older stack entries and their matrix rows; delete is a read-modify-write
// sweep of the matrix column. The scans are bound by the single read port of
// the stack and matrix RAMs. The block does not take a new request before it
// is through with the last one.
// Reset clears all stack counts and the order matrix through valid bits, so
// the block is ready as soon as reset falls; stack contents need none.
// The response sits in an output register: a new request is accepted while
// it waits, but the next response holds in the sequencer until rsp_tready.
// ----------------------------------------------------------------------------
module lock_order_checker_top #(
   parameter int THREADS     = 8,
   parameter int LOCKS       = 64,
   parameter int STACK_DEPTH = 16,
   parameter int CNT_W       = $clog2(STACK_DEPTH + 1),
   parameter int RSP_W       = ((11 + CNT_W) + 7) / 8 * 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   output logic             req_tready,
   input  logic [15:0]      req_tdata,   // mode, thread_id, lock_id, is_recursive
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   output logic [RSP_W-1:0] rsp_tdata    // status, conflict_lock, held, stack_level,
                                         // stack_empty
);

   loc_pkg::cmd_type   cmd;
   loc_pkg::flags_type flags;

   logic [2:0]       rsp_status;
   logic [5:0]       rsp_conflict_lock;
   logic             rsp_held;
   logic [CNT_W-1:0] rsp_stack_level;
   logic             rsp_stack_empty;

   loc_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .flags      (flags),
      .cmd        (cmd)
   );

   loc_dp #(
      .THREADS     (THREADS),
      .LOCKS       (LOCKS),
      .STACK_DEPTH (STACK_DEPTH),
      .CNT_W       (CNT_W)
   ) u_dp (
      .clock             (clock),
      .reset             (reset),
      .req_mode          (req_tdata[2:0]),
      .req_thread_id     (req_tdata[5:3]),
      .req_lock_id       (req_tdata[11:6]),
      .req_is_recursive  (req_tdata[12]),
      .cmd               (cmd),
      .flags             (flags),
      .rsp_tready        (rsp_tready),
      .rsp_tvalid        (rsp_tvalid),
      .rsp_status        (rsp_status),
      .rsp_conflict_lock (rsp_conflict_lock),
      .rsp_held          (rsp_held),
      .rsp_stack_level   (rsp_stack_level),
      .rsp_stack_empty   (rsp_stack_empty)
   );

   assign rsp_tdata = RSP_W'({rsp_stack_empty, rsp_stack_level, rsp_held,
                              rsp_conflict_lock, rsp_status});

endmodule

/* rtl/loc_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// loc_checker
// Port-level checks of the lock order checker request and response streams.
// ----------------------------------------------------------------------------
module loc_checker #(
   parameter int STACK_DEPTH = 16,
   parameter int CNT_W       = $clog2(STACK_DEPTH + 1),
   parameter int RSP_W       = ((11 + CNT_W) + 7) / 8 * 8
) (
   input logic             clock,
   input logic             reset,
   input logic             req_tvalid,
   input logic             req_tready,
   input logic [15:0]      req_tdata,
   input logic             rsp_tvalid,
   input logic             rsp_tready,
   input logic [RSP_W-1:0] rsp_tdata
);

   logic [2:0]       st;
   logic [5:0]       conf;
   logic [CNT_W-1:0] lvl;
   logic             empty;
   logic             req_seen;

   assign st       = rsp_tdata[2:0];
   assign conf     = rsp_tdata[8:3];
   assign lvl      = rsp_tdata[9+CNT_W:10];
   assign empty    = rsp_tdata[10+CNT_W];
   assign req_seen = req_tvalid && req_tready && (req_tdata[2:0] == req_tdata[2:0]);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled response word changed");

   a_empty: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (empty == (lvl == '0)))
      else $error("stack_empty disagrees with stack_level");

   a_level: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (lvl <= CNT_W'(STACK_DEPTH)))
      else $error("stack_level beyond stack depth");

   a_conflict: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && st != loc_pkg::ST_DOUBLE && st != loc_pkg::ST_DEADLOCK
      |-> conf == '0)
      else $error("conflict_lock set without a conflict status");

   a_no_take_twice: assert property (@(posedge clock) disable iff (reset)
      req_seen |=> !req_tready)
      else $error("request accepted on consecutive cycles");

endmodule

bind lock_order_checker_top loc_checker #(.STACK_DEPTH(STACK_DEPTH)) u_loc_checker (.*);
